// File: hdl/arjb_pkg.sv
package arjb_pkg;

  localparam int CAPACITY_DEF    = 32;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int EMA_COEFF   = 1024;
  localparam int UP_SPEED    = 512;
  localparam int PUT_TIMEOUT = 400;
  localparam int DOWN_SLOW   = 6000;
  localparam int DOWN_FAST   = 1000;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_GET   = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LATE      = 3'd1;
  localparam logic [2:0] ST_DUP       = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_OK_AGAIN  = 3'd4;

  localparam logic [1:0] CFG_MIN      = 2'd0;
  localparam logic [1:0] CFG_MAX      = 2'd1;
  localparam logic [1:0] CFG_ADAPTIVE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG,
    S_AVG2,
    S_EVICT_RD,
    S_EVICT_WR,
    S_SEARCH_RD,
    S_SEARCH_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_GET_RD,
    S_GET_DATA,
    S_DONE
  } state_t;

  function automatic logic seq_before(input logic [15:0] x, input logic [15:0] y);
    logic [15:0] d;
    d = x - y;
    return d[15];
  endfunction

endpackage

// File: hdl/adaptive_rtp_jitter_buffer_top.sv
// Adaptive RTP jitter buffer.
// Input channel (in_*): one transaction is one request: put, get, flush or a
// one-millisecond tick. Every request yields exactly one result transaction
// on the out_* channel with a status, the popped frame for a successful get,
// and the occupancy and wish size after the request.
// Configuration (cfg_*): index 0 min_frames, 1 max_frames, 2 adaptive_mode.
// Write only while the block is idle; cfg_ready is always high.
// Frames live in one synchronous slot memory with one write and one read
// port, kept sorted by wrap-aware sequence number. A put reads and moves
// entries one at a time: eviction of the oldest frame, the insert search and
// the shift each visit an entry with a read state, then a write or check state.
// A get reads the head and shifts the remaining entries down; flush and tick
// go straight to the result. The adaptive average update adds the S_AVG2 state
// to a put. One item is in work at a time; in_tready drops while it is
// processed and rises again the cycle after its result is loaded.
// The result sits in an output register; a stalled receiver holds it, and
// the next item is worked on but waits for the register before it finishes.
// Reset (rst_n low, synchronous) empties the buffer, restores the register
// defaults and sets wish to min_frames. No memory clearing is needed.
module adaptive_rtp_jitter_buffer_top import arjb_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // seq_num, rtp_time, marker_bit, payload_kind, source_id, payload_handle
  input  logic [(88+HANDLE_BITS+7)/8*8-1:0] in_tdata,
  // req_type
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, out_seq, out_rtp_time, out_marker, out_payload_kind, out_source_id,
  // out_payload_handle, occupancy, wish_size, zero fill
  output logic [(103+HANDLE_BITS+7)/8*8-1:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [5:0]   cfg_data
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int EW  = 88 + HANDLE_BITS;  // seq, ts, marker, pt, src, handle
  localparam int IW  = (88 + HANDLE_BITS + 7) / 8 * 8;
  localparam int OW  = (103 + HANDLE_BITS + 7) / 8 * 8;
  localparam logic [6:0] CAP_LIM = (CAPACITY < 64) ? 7'(CAPACITY) : 7'd63;

  // ---------------- configuration ----------------
  logic [5:0] min_r, max_r;
  logic       adapt_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= 6'd1;
      max_r   <= 6'd16;
      adapt_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN:      min_r   <= cfg_data;
        CFG_MAX:      max_r   <= cfg_data;
        CFG_ADAPTIVE: adapt_r <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // Capacity in use: zero reads as one, anything above CAPACITY clamps.
  logic [6:0] cap;
  always_comb begin
    cap = {1'b0, max_r};
    if (cap == 7'd0) cap = 7'd1;
    if (cap > CAP_LIM) cap = CAP_LIM;
  end

  // ---------------- state ----------------
  state_t        st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [5:0]    wish_r, wish_nxt;
  logic signed [31:0] avg_r, avg_nxt;
  logic [15:0]   lput_r, lput_nxt, lget_r, lget_nxt;
  logic [31:0]   psrc_r, psrc_nxt, now_r, now_nxt, lpt_r, lpt_nxt;
  logic          run_r, run_nxt;
  logic [12:0]   tmr_r, tmr_nxt;
  logic          ton_r, ton_nxt;
  logic [CW-1:0] idx_r, idx_nxt;   // walk index
  logic [CW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] req_r;
  logic [1:0]    typ_r;
  logic [OW-1:0] res_r, res_nxt;   // result being built
  logic [OW-1:0] out_r;            // result on offer
  logic          ov_r, ov_nxt;
  logic signed [47:0] prod_r, prod_nxt;  // (adiff - avg) * s
  logic          adn_r, adn_nxt;         // not set by any state; only holds its value

  // memory
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [EW-1:0] wd, rd;

  arjb_slot_mem #(.CAPACITY(CAPACITY), .WIDTH(EW)) u_mem (
    .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd)
  );

  // request fields
  logic [15:0] q_seq;
  logic [31:0] q_src;
  logic        q_mark;
  logic [EW-1:0] q_entry;
  assign q_seq   = req_r[15:0];
  assign q_mark  = req_r[48];
  assign q_src   = req_r[87:56];
  assign q_entry = req_r[EW-1:0];

  logic [15:0] rd_seq;
  assign rd_seq = rd[15:0];

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r <= in_tdata;
      typ_r <= in_tuser;
    end
    if (st_r == S_DONE && (!ov_r || out_tready)) begin
      out_r <= res_nxt;
    end
    prod_r <= prod_nxt;
    adn_r  <= adn_nxt;
    res_r  <= res_nxt;
    pos_r  <= pos_nxt;
    idx_r  <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; wish_r <= 6'd1; avg_r <= '0;
      lput_r <= '0; lget_r <= '0; psrc_r <= '0; now_r <= '0; lpt_r <= '0;
      run_r <= 1'b0; tmr_r <= '0; ton_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; wish_r <= wish_nxt; avg_r <= avg_nxt;
      lput_r <= lput_nxt; lget_r <= lget_nxt; psrc_r <= psrc_nxt; now_r <= now_nxt;
      lpt_r <= lpt_nxt; run_r <= run_nxt; tmr_r <= tmr_nxt; ton_r <= ton_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Result packing helper values.
  function automatic logic [OW-1:0] pack(input logic [2:0] s, input logic [EW-1:0] e,
                                         input logic [5:0] occ, input logic [5:0] w);
    logic [OW-1:0] r;
    r = '0;
    r[2:0] = s;
    r[3 +: EW] = e;
    r[3+EW +: 6] = occ;
    r[9+EW +: 6] = w;
    return r;
  endfunction

  // average step helpers
  logic signed [31:0] rdiff;
  logic signed [31:0] adiff, dlt;
  logic [10:0] sfac;
  logic signed [47:0] avg_new;
  logic [31:0] wq;
  logic [6:0]  wcl;
  logic [13:0] dt;
  logic [31:0] gap;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; wish_nxt = wish_r; avg_nxt = avg_r;
    lput_nxt = lput_r; lget_nxt = lget_r; psrc_nxt = psrc_r; now_nxt = now_r;
    lpt_nxt = lpt_r; run_nxt = run_r; tmr_nxt = tmr_r; ton_nxt = ton_r;
    idx_nxt = idx_r; pos_nxt = pos_r; res_nxt = res_r; prod_nxt = prod_r;
    adn_nxt = adn_r;
    ov_nxt = ov_r && !out_tready;
    we = 1'b0; wa = '0; wd = q_entry; ra = '0;
    rdiff = 32'(signed'(lput_r + 16'd1 - q_seq));
    adiff = (rdiff < 0 ? -rdiff : rdiff) <<< 10;
    dlt = adiff - avg_r;
    sfac = (adiff > avg_r) ? 11'(UP_SPEED) : (wish_r > 6'd2) ? 11'd1 :
           (wish_r > 6'd1) ? 11'd2 : 11'd3;
    avg_new = 48'(avg_r) + prod_r / 48'sd1024;
    wq = (avg_new > 0) ? 32'(avg_new[47:10]) : 32'd0;
    wcl = (wq > 32'(min_r)) ? ((wq > 32'd63) ? 7'd63 : 7'(wq)) : {1'b0, min_r};
    if (wcl >= cap) wcl = cap - 7'd1;
    dt = (7'(wcl) + 7'd1 == {1'b0, wish_r}) ? 14'(DOWN_SLOW) : 14'(DOWN_FAST);
    gap = now_r - lpt_r;

    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            REQ_PUT: begin
              st_nxt = S_AVG;
            end
            REQ_GET: st_nxt = S_GET_RD;
            default: st_nxt = S_DONE;
          endcase
        end
      end
      // Put: flush checks, then optional average update or late check.
      S_AVG: begin
        if ((psrc_r != 32'd0 && psrc_r != q_src) ||
            (lpt_r != 32'd0 && gap > 32'(PUT_TIMEOUT) && q_mark)) begin
          cnt_nxt = '0; run_nxt = 1'b0; lget_nxt = '0;
          st_nxt = S_EVICT_RD;
        end else if (run_r && adapt_r && lget_r != 16'd0) begin
          prod_nxt = 48'(dlt) * 48'(signed'({1'b0, sfac}));
          st_nxt = S_AVG2;
        end else if (run_r && lget_r != 16'd0 &&
                     seq_before(q_seq, lget_r + 16'd1)) begin
          res_nxt = pack(ST_LATE, '0, 6'(cnt_r), wish_r);
          st_nxt = S_DONE;
        end else begin
          st_nxt = S_EVICT_RD;
        end
        lpt_nxt = now_r;
        psrc_nxt = q_src;
        idx_nxt = CW'(1);
      end
      S_AVG2: begin
        avg_nxt = 32'(avg_new);
        if (7'(wcl) > {1'b0, wish_r}) begin
          wish_nxt = 6'(wcl);
          ton_nxt = 1'b0; tmr_nxt = '0;
        end else if (7'(wcl) < {1'b0, wish_r}) begin
          if (!ton_r || 14'(tmr_r) > dt) begin
            ton_nxt = 1'b1; tmr_nxt = 13'(dt);
          end
        end else begin
          ton_nxt = 1'b0; tmr_nxt = '0;
        end
        if (seq_before(q_seq, lget_r + 16'd1)) begin
          res_nxt = pack(ST_LATE, '0, 6'(cnt_r), wish_nxt);
          st_nxt = S_DONE;
        end else begin
          st_nxt = S_EVICT_RD;
        end
      end
      // Evict: shift entries down by one when full.
      S_EVICT_RD: begin
        if (7'(cnt_r) < cap) begin
          idx_nxt = cnt_r;
          st_nxt = S_SEARCH_RD;
        end else if (idx_r >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          idx_nxt = cnt_r - CW'(1);
          st_nxt = S_SEARCH_RD;
        end else begin
          ra = AW'(idx_r);
          st_nxt = S_EVICT_WR;
        end
      end
      S_EVICT_WR: begin
        we = 1'b1; wa = AW'(idx_r - CW'(1)); wd = rd;
        idx_nxt = idx_r + CW'(1);
        st_nxt = S_EVICT_RD;
      end
      // Search from the tail; idx is the count of entries before the candidate slot.
      S_SEARCH_RD: begin
        if (idx_r == '0) begin
          pos_nxt = '0; idx_nxt = cnt_r; st_nxt = S_SHIFT_RD;
        end else begin
          ra = AW'(idx_r - CW'(1));
          st_nxt = S_SEARCH_CHK;
        end
      end
      S_SEARCH_CHK: begin
        if (seq_before(rd_seq, q_seq)) begin
          pos_nxt = idx_r; idx_nxt = cnt_r; st_nxt = S_SHIFT_RD;
        end else if (rd_seq == q_seq) begin
          res_nxt = pack(ST_DUP, '0, 6'(cnt_r), wish_r);
          st_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r - CW'(1); st_nxt = S_SEARCH_RD;
        end
      end
      S_SHIFT_RD: begin
        if (idx_r <= pos_r) begin
          st_nxt = S_INSERT;
        end else begin
          ra = AW'(idx_r - CW'(1));
          st_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1; wa = AW'(idx_r); wd = rd;
        idx_nxt = idx_r - CW'(1);
        st_nxt = S_SHIFT_RD;
      end
      S_INSERT: begin
        we = 1'b1; wa = AW'(pos_r); wd = q_entry;
        cnt_nxt = cnt_r + CW'(1);
        run_nxt = 1'b1; lput_nxt = q_seq;
        res_nxt = pack(ST_OK, '0, 6'(cnt_nxt), wish_r);
        st_nxt = S_DONE;
      end
      // Get: read head, then remove it by shifting the remaining entries down.
      S_GET_RD: begin
        ra = '0;
        if (cnt_r == '0 || {{(32-CW){1'b0}}, cnt_r} <= 32'(wish_r)) begin
          res_nxt = pack(ST_UNDERFLOW, '0, 6'(cnt_r), wish_r);
          st_nxt = S_DONE;
        end else begin
          idx_nxt = CW'(1);
          st_nxt = S_GET_DATA;
        end
      end
      S_GET_DATA: begin
        if (idx_r == CW'(1)) begin
          lget_nxt = rd_seq;
          res_nxt = pack(ST_OK, rd, 6'(cnt_r - CW'(1)), wish_r);
          if (adapt_r && 32'(cnt_r - CW'(1)) > 32'(wish_r)) res_nxt[2:0] = ST_OK_AGAIN;
        end
        if (idx_r >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          st_nxt = S_DONE;
        end else begin
          ra = AW'(idx_r);
          if (idx_r != CW'(1)) begin
            we = 1'b1; wa = AW'(idx_r - CW'(2)); wd = rd;
          end
          idx_nxt = idx_r + CW'(1);
          st_nxt = S_GET_DATA;
        end
        // final pending write of last read entry
        if (idx_r >= cnt_r && idx_r != CW'(1)) begin
          we = 1'b1; wa = AW'(idx_r - CW'(2)); wd = rd;
        end
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          if (typ_r == REQ_FLUSH) begin
            cnt_nxt = '0; run_nxt = 1'b0; lget_nxt = '0;
            res_nxt = pack(ST_OK, '0, 6'd0, wish_r);
          end else if (typ_r == REQ_TICK) begin
            now_nxt = now_r + 32'd1;
            if (ton_r) begin
              if (tmr_r == 13'd1 || tmr_r == 13'd0) begin
                tmr_nxt = '0; ton_nxt = 1'b0;
                if (wish_r > min_r) wish_nxt = wish_r - 6'd1;
              end else begin
                tmr_nxt = tmr_r - 13'd1;
              end
            end
            res_nxt = pack(ST_OK, '0, 6'(cnt_r), wish_nxt);
          end
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hdl/arjb_slot_mem.sv
module arjb_slot_mem import arjb_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int WIDTH    = 104,
  localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
